### rtl/core/min_priority_queue_core_macros.svh
// Assertion macros for the priority queue core.
`ifndef MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define MPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/mpq_pkg.sv
package mpq_pkg;
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_EXTRACT = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_EXTRACTED = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	localparam int KEY_W = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W = 7;
endpackage

### rtl/core/min_priority_queue_core.sv
// Channel  | Ports                          | Transfer
// command  | start, busy, cmd, key_in       | start high and busy low at clk rise
// result   | done, key_out, status, occupancy| done high for one cycle
// Insert, clear, empty extract and full insert: result transfer in the cycle after the
// command transfer; a new command can transfer once busy has fallen after done.
// Extract: scan of the key memory, one read per cycle; the result transfers after
// the SCAN states (none for a single entry), LAST, MOVE and FIN, the next command after DONE;
// the single read port of the key memory sets the length of the scan.
// arst_n clears the count and control; the memory holds no reset.
// The receiver cannot stall: done is a one-cycle strobe.
`include "min_priority_queue_core_macros.svh"
module min_priority_queue_core import mpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              cmd,
	input  logic signed [KEY_W-1:0] key_in,
	output logic                    done,
	output logic signed [KEY_W-1:0] key_out,
	output logic [STATUS_W-1:0]     status,
	output logic [OCC_W-1:0]        occupancy
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_LAST = 3'd2;
	localparam logic [2:0] S_MOVE = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;     // next address to read
	logic [AW-1:0]           cmp_q;     // address of data now on rdata
	logic                    first_q;
	logic signed [KEY_W-1:0] best_q;
	logic [AW-1:0]           best_idx_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [STATUS_W-1:0]     out_st_q;

	logic                    re, we;
	logic [AW-1:0]           raddr, waddr;
	logic signed [KEY_W-1:0] rdata, wdata;

	mpq_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
		.clk, .re, .raddr, .rdata, .we, .waddr, .wdata
	);

	wire accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign key_out = out_key_q;
	assign status = out_st_q;
	assign occupancy = OCC_W'(count_q);

	// compare the key now on rdata against the running minimum
	wire take = first_q || (rdata < best_q);
	wire signed [KEY_W-1:0] nbest = take ? rdata : best_q;
	wire [AW-1:0] nbidx = take ? cmp_q : best_idx_q;

	always_comb begin
		re = 1'b0;
		raddr = AW'(idx_q);
		we = 1'b0;
		waddr = AW'(count_q);
		wdata = key_in;
		if (accept && cmd == CMD_INSERT && count_q < CW'(CAPACITY)) begin
			we = 1'b1;
		end
		if (state_q == S_IDLE && accept && cmd == CMD_EXTRACT && count_q != '0) begin
			re = 1'b1;
			raddr = '0;
		end else if (state_q == S_SCAN) begin
			re = 1'b1;
		end
		if (state_q == S_LAST) begin
			// fetch the last entry to fill the hole
			re = 1'b1;
			raddr = AW'(count_q - CW'(1));
		end
		if (state_q == S_FIN) begin
			we = 1'b1;
			waddr = best_idx_q;
			wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			cmp_q <= '0;
			first_q <= 1'b0;
			best_q <= '0;
			best_idx_q <= '0;
			out_key_q <= '0;
			out_st_q <= ST_INSERTED;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_key_q <= '0;
						state_q <= S_DONE;
						if (cmd[1]) begin
							count_q <= '0;
							out_st_q <= ST_CLEARED;
						end else if (cmd == CMD_INSERT) begin
							if (count_q < CW'(CAPACITY)) begin
								count_q <= count_q + CW'(1);
								out_st_q <= ST_INSERTED;
							end else begin
								out_st_q <= ST_FULL;
							end
						end else if (count_q == '0) begin
							out_st_q <= ST_EMPTY;
						end else begin
							out_st_q <= ST_EXTRACTED;
							idx_q <= CW'(1);
							cmp_q <= '0;
							first_q <= 1'b1;
							state_q <= (count_q == CW'(1)) ? S_LAST : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					best_q <= nbest;
					best_idx_q <= nbidx;
					first_q <= 1'b0;
					cmp_q <= AW'(idx_q);
					idx_q <= idx_q + CW'(1);
					if (idx_q + CW'(1) >= count_q) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					// fold in the final scanned entry
					best_q <= nbest;
					best_idx_q <= nbidx;
					first_q <= 1'b0;
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					out_key_q <= best_q;
					count_q <= count_q - CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MPQ_ASSERT_IMPL(a_cap, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`MPQ_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`MPQ_ASSERT_NEXT(a_empty_keeps, clk, arst_n,
		done && status == ST_EMPTY, count_q == '0)
endmodule

### rtl/core/mpq_store.sv
module mpq_store import mpq_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                    clk,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic signed [KEY_W-1:0] rdata,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [KEY_W-1:0] wdata
);
	logic signed [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
